### hdl/bsa_pkg.sv
// Shared types and constants of the 24-bit bitmap to ARGB stream decoder.
package bsa_pkg;

   localparam int ROW_W = 10;               // row and column counters
   localparam int DIM_W = 11;               // image width or height, up to 1024
   localparam int PROD_W = ROW_W + DIM_W;   // rows below times width

   localparam logic [31:0] OFFSET_POS   = 32'd10;
   localparam logic [31:0] WIDTH_POS    = 32'd18;
   localparam logic [31:0] HEIGHT_POS   = 32'd22;
   localparam logic [31:0] HDR_LAST_POS = 32'd25;
   localparam logic [31:0] MIN_OFFSET   = 32'd26;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_SKIP   = 4'b0010,
      PH_DATA   = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_address;
      logic [31:0] color;
      logic        last_pixel;
      logic        header_error;
   } rsp_type;

   // One classified item from the parser: a finished pixel or a header fault.
   typedef struct packed {
      logic             err;
      logic             last;
      logic [ROW_W-1:0] rows_below;
      logic [DIM_W-1:0] width;
      logic [ROW_W-1:0] column;
      logic [23:0]      rgb;
   } cmd_type;

endpackage

### hdl/bsa_fifo.sv
// Small register queue with push/full and pop/empty sides.
module bsa_fifo import bsa_pkg::*; #(
   parameter type item_type = logic,
   parameter int  DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type wr_item,
   input  logic     pop,
   output logic     empty,
   output item_type rd_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

### hdl/bsa_front.sv
// Byte parser: header capture, offset skip, pixel assembly and row/column tracking.
module bsa_front import bsa_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_item,
   output logic    cmd_push,
   input  logic    cmd_full,
   output cmd_type cmd_item
);

   phase_type        phase_ff, phase_in, ph;
   logic [31:0]      pos_ff, pos_in, pos;
   logic [31:0]      off_ff, off_in, off;
   logic [31:0]      wid_ff, wid_in, wid;
   logic [31:0]      hgt_ff, hgt_in, hgt;
   logic [ROW_W-1:0] row_ff, row_in, row;
   logic [ROW_W-1:0] col_ff, col_in, col;
   logic [1:0]       bip_ff, bip_in, bip;
   logic [1:0]       pad_ff, pad_in, pad;
   logic [15:0]      part_ff, part_in, part;
   logic             accept;
   logic             emit;
   logic             do_data;
   logic [1:0]       lane;
   logic             row_end;
   logic             is_last;
   cmd_type          cmd;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept && emit;
   assign cmd_item = cmd;

   always_comb begin
      // a start mark restarts the parse with this byte as file byte 0
      ph   = req_item.file_start ? PH_HEADER : phase_ff;
      pos  = req_item.file_start ? '0 : pos_ff;
      off  = req_item.file_start ? '0 : off_ff;
      wid  = req_item.file_start ? '0 : wid_ff;
      hgt  = req_item.file_start ? '0 : hgt_ff;
      row  = req_item.file_start ? '0 : row_ff;
      col  = req_item.file_start ? '0 : col_ff;
      bip  = req_item.file_start ? '0 : bip_ff;
      pad  = req_item.file_start ? '0 : pad_ff;
      part = req_item.file_start ? '0 : part_ff;

      phase_in = ph;
      pos_in   = pos;
      off_in   = off;
      wid_in   = wid;
      hgt_in   = hgt;
      row_in   = row;
      col_in   = col;
      bip_in   = bip;
      pad_in   = pad;
      part_in  = part;
      emit     = 1'b0;
      do_data  = 1'b0;
      cmd      = '0;
      lane     = pos[1:0] - 2'd2;
      row_end  = ({1'b0, col} + 1'b1) == wid[DIM_W-1:0];
      is_last  = row_end && (({1'b0, row} + 1'b1) == hgt[DIM_W-1:0]);

      case (ph)
         PH_HEADER: begin
            pos_in = pos + 1'b1;
            if (pos inside {[OFFSET_POS:OFFSET_POS + 32'd3]}) begin
               off_in[{lane, 3'b000} +: 8] = off[{lane, 3'b000} +: 8] | req_item.data_byte;
            end else if (pos inside {[WIDTH_POS:WIDTH_POS + 32'd3]}) begin
               wid_in[{lane, 3'b000} +: 8] = wid[{lane, 3'b000} +: 8] | req_item.data_byte;
            end else if (pos inside {[HEIGHT_POS:HEIGHT_POS + 32'd3]}) begin
               hgt_in[{lane, 3'b000} +: 8] = hgt[{lane, 3'b000} +: 8] | req_item.data_byte;
            end
            if (pos == HDR_LAST_POS) begin
               if (off_in < MIN_OFFSET || wid_in == '0 || wid_in > 32'(MAX_WIDTH) ||
                   hgt_in == '0 || hgt_in > 32'(MAX_HEIGHT)) begin
                  phase_in = PH_DONE;
                  emit     = 1'b1;
                  cmd.err  = 1'b1;
               end else if (off_in == MIN_OFFSET) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (pos != off) begin
               pos_in = pos + 1'b1;
            end else begin
               // offset reached: this byte is already pixel data
               phase_in = PH_DATA;
               do_data  = 1'b1;
            end
         end
         PH_DATA: begin
            do_data = 1'b1;
         end
         default: begin
         end
      endcase

      if (do_data) begin
         if (pad != 2'd0) begin
            pad_in = pad - 1'b1;
         end else if (bip == 2'd0) begin
            part_in = {8'h00, req_item.data_byte};
            bip_in  = 2'd1;
         end else if (bip == 2'd1) begin
            part_in = {req_item.data_byte, part[7:0]};
            bip_in  = 2'd2;
         end else begin
            bip_in         = 2'd0;
            emit           = 1'b1;
            cmd.last       = is_last;
            cmd.rows_below = ROW_W'(hgt[DIM_W-1:0] - 1'b1 - {1'b0, row});
            cmd.width      = wid[DIM_W-1:0];
            cmd.column     = col;
            cmd.rgb        = {req_item.data_byte, part};
            if (row_end) begin
               col_in = '0;
               row_in = row + 1'b1;
               pad_in = wid[1:0];
            end else begin
               col_in = col + 1'b1;
            end
            if (is_last) begin
               phase_in = PH_DONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         off_ff   <= '0;
         wid_ff   <= '0;
         hgt_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         bip_ff   <= '0;
         pad_ff   <= '0;
         part_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         off_ff   <= off_in;
         wid_ff   <= wid_in;
         hgt_ff   <= hgt_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         bip_ff   <= bip_in;
         pad_ff   <= pad_in;
         part_ff  <= part_in;
      end
   end

endmodule

### hdl/bsa_back.sv
// Address generator: row offset multiply, then base and column add into the result queue.
module bsa_back import bsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] image_base,
   input  logic        cmd_empty,
   output logic        cmd_pop,
   input  cmd_type     cmd_item,
   output logic        rsp_push,
   input  logic        rsp_full,
   output rsp_type     rsp_item
);

   logic              s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0] s1_prod_ff;
   logic [ROW_W-1:0]  s1_col_ff;
   logic [23:0]       s1_rgb_ff;
   logic              s1_last_ff;
   logic              s1_err_ff;
   logic              advance;

   // stage one moves on when empty or when its item drains this cycle
   assign rsp_push    = s1_valid_ff && !rsp_full;
   assign advance     = !s1_valid_ff || !rsp_full;
   assign cmd_pop     = advance && !cmd_empty;
   assign s1_valid_in = cmd_pop ? 1'b1 : (s1_valid_ff && rsp_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         s1_prod_ff <= {{DIM_W{1'b0}}, cmd_item.rows_below} *
                       {{ROW_W{1'b0}}, cmd_item.width};
         s1_col_ff  <= cmd_item.column;
         s1_rgb_ff  <= cmd_item.rgb;
         s1_last_ff <= cmd_item.last;
         s1_err_ff  <= cmd_item.err;
      end
   end

   always_comb begin
      rsp_item = '0;
      if (s1_err_ff) begin
         rsp_item.header_error = 1'b1;
      end else begin
         rsp_item.pixel_address = image_base + {{(32 - PROD_W){1'b0}}, s1_prod_ff} +
                                  {{(32 - ROW_W){1'b0}}, s1_col_ff};
         rsp_item.color         = {ALPHA_OPAQUE, s1_rgb_ff};
         rsp_item.last_pixel    = s1_last_ff;
      end
   end

endmodule

### hdl/bmp24_stream_to_argb.sv
// Top level of the 24-bit bitmap byte stream to ARGB pixel decoder.
// Takes one file byte per clock cycle while the command queue is not full, and
// sustains that rate through pixel data: the parser handles each byte as it is
// accepted, and the address path registers the row offset multiply and then
// does the base and column add. A pixel passes the command queue and the stage-one
// register on its way to the result queue, and so does a header fault at byte 25.
// Four-entry queues sit between parser and address path and in front of the
// result ports, so req_full rises only once both have filled while pop stays low.
// Write image_base on the csr port only between files, with no results outstanding.
module bmp24_stream_to_argb import bsa_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_item,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic [31:0] image_base_ff, image_base_in;
   logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type     cmd_wr, cmd_rd;
   logic        rsp_push, rsp_full;
   rsp_type     rsp_wr;

   assign csr_ready     = 1'b1;
   assign image_base_in = (csr_valid && csr_ready) ? csr_data : image_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_base_ff <= '0;
      end else begin
         image_base_ff <= image_base_in;
      end
   end

   bsa_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_item (cmd_wr)
   );

   bsa_fifo #(
      .item_type (cmd_type),
      .DEPTH     (4)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .full    (cmd_full),
      .wr_item (cmd_wr),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_item (cmd_rd)
   );

   bsa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .image_base (image_base_ff),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .cmd_item   (cmd_rd),
      .rsp_push   (rsp_push),
      .rsp_full   (rsp_full),
      .rsp_item   (rsp_wr)
   );

   bsa_fifo #(
      .item_type (rsp_type),
      .DEPTH     (4)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .full    (rsp_full),
      .wr_item (rsp_wr),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_item (rsp_item)
   );

   a_fault_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.header_error) |->
         (rsp_item.pixel_address == '0 && rsp_item.color == '0 && !rsp_item.last_pixel))
      else $error("header fault item carries non-zero pixel fields");

   a_pixel_opaque: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_item.header_error) |-> (rsp_item.color[31:24] == ALPHA_OPAQUE))
      else $error("pixel item without opaque alpha");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule
